>>> hdl/ssl_pkg.sv
package ssl_pkg;

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_MIN_ANGLE   = 3'd0;
  localparam logic [2:0] REG_MAX_ANGLE   = 3'd1;
  localparam logic [2:0] REG_SLEW_SPEED  = 3'd2;
  localparam logic [2:0] REG_REVERSE_DIR = 3'd3;
  localparam logic [2:0] REG_START_ANGLE = 3'd4;

  localparam int ADDR_W = 5;

  // reset values
  localparam logic [7:0] RST_MIN_ANGLE   = 8'd0;
  localparam logic [7:0] RST_MAX_ANGLE   = 8'd180;
  localparam logic [7:0] RST_SLEW_SPEED  = 8'd180;
  localparam logic       RST_REVERSE_DIR = 1'b0;
  localparam logic [7:0] RST_START_ANGLE = 8'd90;

  // angle and pulse constants
  localparam int ANGLE_FULL    = 180;
  localparam int PULSE_MIN_US  = 600;
  localparam int PULSE_SPAN_US = 1900;
  localparam int MS_PER_S      = 1000;

  // step limit: speed*elapsed at or above this gives the saturated step
  localparam int STEP_SAT = 255;
  localparam logic [39:0] SAT_PROD = 40'((STEP_SAT + 1) * MS_PER_S);

  // floor(p/1000) = (p * RECIP) >> RECIP_SHIFT, exact for p below SAT_PROD
  localparam int RECIP_SHIFT = 28;
  localparam logic [18:0] RECIP = 19'(((64'd1 << RECIP_SHIFT) + MS_PER_S - 1) / MS_PER_S);

  typedef struct packed {
    logic [7:0] min_angle;
    logic [7:0] max_angle;
    logic [7:0] slew_speed;
    logic       reverse_direction;
    logic [7:0] start_angle;
  } cfg_t;

  // pulse width for each angle 0..180
  typedef logic [11:0] pulse_lut_t [0:ANGLE_FULL];

  function automatic pulse_lut_t build_pulse_lut();
    pulse_lut_t lut;
    for (int i = 0; i <= ANGLE_FULL; i++) begin
      lut[i] = 12'(PULSE_MIN_US + (i * PULSE_SPAN_US) / ANGLE_FULL);
    end
    return lut;
  endfunction

  localparam pulse_lut_t PULSE_LUT = build_pulse_lut();

endpackage

>>> hdl/ssl_regs.sv
module ssl_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ssl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output ssl_pkg::cfg_t             cfg,
  output logic                      start_load
);
  import ssl_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // preset of the current angle in the cycle after a start angle write,
  // once the register holds the new value
  always_ff @(posedge clk) begin
    if (rst) begin
      start_load <= 1'b0;
    end else begin
      start_load <= wr_en && (reg_idx == REG_START_ANGLE);
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_angle         <= RST_MIN_ANGLE;
      cfg.max_angle         <= RST_MAX_ANGLE;
      cfg.slew_speed        <= RST_SLEW_SPEED;
      cfg.reverse_direction <= RST_REVERSE_DIR;
      cfg.start_angle       <= RST_START_ANGLE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_ANGLE:   cfg.min_angle         <= pwdata[7:0];
        REG_MAX_ANGLE:   cfg.max_angle         <= pwdata[7:0];
        REG_SLEW_SPEED:  cfg.slew_speed        <= pwdata[7:0];
        REG_REVERSE_DIR: cfg.reverse_direction <= pwdata[0];
        REG_START_ANGLE: cfg.start_angle       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_MIN_ANGLE:   prdata = {24'd0, cfg.min_angle};
      REG_MAX_ANGLE:   prdata = {24'd0, cfg.max_angle};
      REG_SLEW_SPEED:  prdata = {24'd0, cfg.slew_speed};
      REG_REVERSE_DIR: prdata = {31'd0, cfg.reverse_direction};
      REG_START_ANGLE: prdata = {24'd0, cfg.start_angle};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

>>> hdl/ssl_step.sv
module ssl_step (
  input  logic          clk,
  input  logic          rst,
  input  ssl_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    target_angle,
  input  logic [31:0]   now_ms,
  output logic          st_valid,
  input  logic          st_ready,
  output logic [7:0]    st_target,
  output logic [7:0]    st_step
);
  import ssl_pkg::*;

  logic        r1, r2, r3;
  logic        v1, v2, v3;
  logic [31:0] last_time;
  logic [7:0]  t1, t2, t3;
  logic [31:0] el1;
  logic [39:0] prod2;
  logic [36:0] q3;
  logic        sat3;
  logic [7:0]  t_clamp;
  logic [39:0] prod_next;
  logic [36:0] q_next;

  // stage advance when the next slot is free
  assign r3       = !v3 || st_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  // target clamp, max tested first
  always_comb begin
    if (t1 > cfg.max_angle) begin
      t_clamp = cfg.max_angle;
    end else if (t1 < cfg.min_angle) begin
      t_clamp = cfg.min_angle;
    end else begin
      t_clamp = t1;
    end
  end

  assign prod_next = 40'(cfg.slew_speed) * 40'(el1);
  assign q_next    = 37'(prod2[17:0]) * 37'(RECIP);

  // valid flags and last timestamp
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      last_time <= 32'd0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (in_valid && r1) last_time <= now_ms;
    end
  end

  // elapsed time, product, reciprocal divide
  always_ff @(posedge clk) begin
    if (in_valid && r1) begin
      t1  <= target_angle;
      el1 <= now_ms - last_time;
    end
    if (v1 && r2) begin
      t2    <= t_clamp;
      prod2 <= prod_next;
    end
    if (v2 && r3) begin
      t3   <= t2;
      q3   <= q_next;
      sat3 <= (prod2 >= SAT_PROD);
    end
  end

  assign st_valid  = v3;
  assign st_target = t3;
  assign st_step   = sat3 ? 8'(STEP_SAT) : q3[RECIP_SHIFT+7:RECIP_SHIFT];

endmodule

>>> hdl/ssl_track.sv
module ssl_track (
  input  logic          clk,
  input  logic          rst,
  input  ssl_pkg::cfg_t cfg,
  input  logic          start_load,
  input  logic          st_valid,
  output logic          st_ready,
  input  logic [7:0]    st_target,
  input  logic [7:0]    st_step,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    angle_out,
  output logic [11:0]   pulse_us
);
  import ssl_pkg::*;

  logic       r4, r5;
  logic       v4;
  logic [7:0] current_angle;
  logic [7:0] current_angle_next;
  logic [7:0] a4;
  logic [8:0] up_sum;
  logic [8:0] down_lim;
  logic [7:0] pulse_idx;
  logic [11:0] pulse_next;

  assign r5       = !out_valid || out_ready;
  assign r4       = !v4 || r5;
  assign st_ready = r4;

  // move toward the target, stopping exactly on it
  assign up_sum   = {1'b0, current_angle} + {1'b0, st_step};
  assign down_lim = {1'b0, st_target} + {1'b0, st_step};

  always_comb begin
    if (st_target > current_angle) begin
      current_angle_next = (up_sum >= {1'b0, st_target}) ? st_target : up_sum[7:0];
    end else if (st_target < current_angle) begin
      current_angle_next = ({1'b0, current_angle} <= down_lim) ? st_target
                                                               : current_angle - st_step;
    end else begin
      current_angle_next = current_angle;
    end
  end

  // pulse width lookup, zero above full scale
  always_comb begin
    pulse_idx  = cfg.reverse_direction ? 8'(ANGLE_FULL) - a4 : a4;
    pulse_next = (a4 > 8'(ANGLE_FULL)) ? 12'd0 : PULSE_LUT[pulse_idx];
  end

  // angle state and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      current_angle <= RST_START_ANGLE;
      v4            <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (start_load) begin
        current_angle <= cfg.start_angle;
      end else if (st_valid && r4) begin
        current_angle <= current_angle_next;
      end
      if (r4) v4 <= st_valid;
      if (r5) out_valid <= v4;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (st_valid && r4) a4 <= current_angle_next;
    if (v4 && r5) begin
      angle_out <= a4;
      pulse_us  <= pulse_next;
    end
  end

endmodule

>>> hdl/servo_slew_limited_pulse_gen.sv
// servo channel with slew limited angle and pulse width mapping
//
// input channel (in_valid/in_ready): one transfer carries a target angle and
// a millisecond timestamp. the target is clamped to min/max, and the angle
// moves toward it by at most floor(slew_speed*elapsed/1000) degrees, step
// capped at 255. elapsed is the timestamp minus the previous one, mod 2^32.
// output channel (out_valid/out_ready): one transfer per input carries the
// new angle and its pulse width, 600 + angle*1900/180 us (reversed if set),
// or 0 for angles above 180.
// throughput: one item per cycle while the output is not stalled; the angle
// update loop is combinational around current_angle, and the multiply,
// reciprocal divide and pulse lookup are pipelined ahead of and behind it.
// a stalled receiver holds the output register; each stage keeps accepting
// while it has a free slot, so up to five items can be in flight.
// reset clears the pipeline, loads the register defaults, sets the angle to
// 90 and the stored timestamp to 0. a start_angle write presets the angle.
// registers (apb, byte address 4*i): min_angle, max_angle, slew_speed,
// reverse_direction, start_angle.
module servo_slew_limited_pulse_gen (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 target_angle,
  input  logic [31:0]                now_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 angle_out,
  output logic [11:0]                pulse_us
);
  import ssl_pkg::*;

  cfg_t       cfg;
  logic       start_load;
  logic       st_valid;
  logic       st_ready;
  logic [7:0] st_target;
  logic [7:0] st_step;

  // configuration registers
  ssl_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .start_load (start_load)
  );

  // elapsed time and step size
  ssl_step u_step (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .target_angle (target_angle),
    .now_ms       (now_ms),
    .st_valid     (st_valid),
    .st_ready     (st_ready),
    .st_target    (st_target),
    .st_step      (st_step)
  );

  // angle tracking and pulse output
  ssl_track u_track (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start_load (start_load),
    .st_valid   (st_valid),
    .st_ready   (st_ready),
    .st_target  (st_target),
    .st_step    (st_step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .angle_out  (angle_out),
    .pulse_us   (pulse_us)
  );

endmodule
